/* rtl/core/kmst_pkg.sv */
// keyed monotone state table: shared constants, codes and the
// command and status structs between controller and datapath
// no dependencies
`default_nettype none
package kmst_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int SLOT_LIMIT  = 24;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [7:0] SNAP_HEADER = 8'he0;

  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_OPEN   = 3'd2;
  localparam logic [2:0] ACT_CLOSE  = 3'd3;
  localparam logic [2:0] ACT_UPDATE = 3'd4;
  localparam logic [2:0] ACT_SNAP   = 3'd5;

  localparam logic [2:0] ST_DATA      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN   = 3'd1;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd2;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [2:0] SEL_ERR   = 3'd0;
  localparam logic [2:0] SEL_HDR   = 3'd1;
  localparam logic [2:0] SEL_SLOT  = 3'd2;
  localparam logic [2:0] SEL_IDX   = 3'd3;
  localparam logic [2:0] SEL_VAL   = 3'd4;
  localparam logic [2:0] SEL_ACC   = 3'd5;
  localparam logic [2:0] SEL_FLUSH = 3'd6;

  typedef struct packed {
    logic       ld_in;
    logic       cnt_clr;
    logic       sess_set;
    logic       sess_clr;
    logic       live_clr;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd;
    logic       wr_entry;
    logic       wr_val;
    logic       acc_clr;
    logic       acc_add;
    logic       emit;
    logic [2:0] emit_sel;
    logic [2:0] emit_status;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       session;
    logic       bad_fields;
    logic       slot_bad;
    logic       count_zero;
    logic       full;
    logic       key_match;
    logic       idx_last;
    logic       changed;
    logic       wide;
    logic       acc_ge8;
    logic       acc_left;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/kmst_dp.sv */
// keyed monotone state table datapath: input latch, entry stores,
// merge logic, snapshot packer and output register; uses kmst_pkg
`default_nettype none
module kmst_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kmst_pkg::cmd_t      cmd,
  output kmst_pkg::sts_t           sts,
  input  wire logic [2:0]          in_action,
  input  wire logic [31:0]         in_binding_id,
  input  wire logic [3:0]          in_entry_width,
  input  wire logic                in_merge_max,
  input  wire logic [7:0]          in_incoming_value,
  input  wire logic [7:0]          in_slot,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [7:0]               out_data_byte,
  output logic                     out_last
);

  logic [2:0]  act_r;
  logic [31:0] key_r;
  logic [3:0]  w_r;
  logic        mm_r;
  logic [7:0]  inc_r;
  logic [7:0]  slot_r;

  logic [31:0] key_mem [kmst_pkg::MAX_ENTRIES];
  logic [3:0]  wid_mem [kmst_pkg::MAX_ENTRIES];
  logic        mode_mem [kmst_pkg::MAX_ENTRIES];
  logic [7:0]  val_mem [kmst_pkg::MAX_ENTRIES];
  logic [kmst_pkg::MAX_ENTRIES-1:0] live_r;

  logic [31:0] key_q;
  logic [3:0]  wid_q;
  logic        mode_q;
  logic [7:0]  val_q;
  logic        live_q;

  logic [kmst_pkg::IDX_W-1:0] idx_r;
  logic [kmst_pkg::CNT_W-1:0] cnt_r;
  logic                       sess_r;
  logic [7:0]                 acc_r;
  logic [3:0]                 bits_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [7:0]  cur;
  logic [7:0]  mask;
  logic [7:0]  masked;
  logic [7:0]  merged;
  logic [15:0] sum_buf;
  logic [4:0]  sum_bits;
  logic [kmst_pkg::IDX_W-1:0] wr_at;
  logic [7:0]  byte_nxt;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act_r  <= in_action;
      key_r  <= in_binding_id;
      w_r    <= in_entry_width;
      mm_r   <= in_merge_max;
      inc_r  <= in_incoming_value;
      slot_r <= in_slot;
    end
  end

  assign wr_at = cnt_r[kmst_pkg::IDX_W-1:0];

  // entry stores
  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      key_mem[wr_at]  <= key_r;
      wid_mem[wr_at]  <= w_r;
      mode_mem[wr_at] <= mm_r;
    end
    if (cmd.wr_val) begin
      val_mem[idx_r] <= merged;
    end
    if (cmd.rd) begin
      key_q  <= key_mem[idx_r];
      wid_q  <= wid_mem[idx_r];
      mode_q <= mode_mem[idx_r];
      val_q  <= val_mem[idx_r];
      live_q <= live_r[idx_r];
    end
  end

  // a value reads as zero until written in the current session
  always_ff @(posedge clk) begin
    if (cmd.live_clr) begin
      live_r <= '0;
    end else begin
      if (cmd.wr_entry) begin
        live_r[wr_at] <= 1'b0;
      end
      if (cmd.wr_val) begin
        live_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      cnt_r  <= '0;
      sess_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.wr_entry) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.sess_clr) begin
        sess_r <= 1'b0;
      end else if (cmd.sess_set) begin
        sess_r <= 1'b1;
      end
    end
  end

  // merge
  assign cur    = live_q ? val_q : 8'h00;
  assign mask   = 8'((9'd1 << wid_q) - 9'd1);
  assign masked = inc_r & mask;
  assign merged = mode_q ? ((masked > cur) ? masked : cur) : (cur | masked);

  // snapshot packer
  assign sum_buf  = {8'h00, acc_r} | ({8'h00, cur} << bits_r);
  assign sum_bits = {1'b0, bits_r} + {1'b0, wid_q};

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r  <= 8'h00;
      bits_r <= 4'd0;
    end else if (cmd.acc_add) begin
      if (sum_bits >= 5'd8) begin
        acc_r  <= sum_buf[15:8];
        bits_r <= 4'(sum_bits - 5'd8);
      end else begin
        acc_r  <= sum_buf[7:0];
        bits_r <= sum_bits[3:0];
      end
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      kmst_pkg::SEL_HDR:   byte_nxt = kmst_pkg::SNAP_HEADER;
      kmst_pkg::SEL_SLOT:  byte_nxt = slot_r;
      kmst_pkg::SEL_IDX:   byte_nxt = 8'(idx_r);
      kmst_pkg::SEL_VAL:   byte_nxt = merged;
      kmst_pkg::SEL_ACC:   byte_nxt = sum_buf[7:0];
      kmst_pkg::SEL_FLUSH: byte_nxt = acc_r;
      default:             byte_nxt = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_byte_r   <= byte_nxt;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data_byte = out_byte_r;
  assign out_last      = out_last_r;

  always_comb begin
    sts.action     = act_r;
    sts.session    = sess_r;
    sts.bad_fields = (key_r == 32'd0) || (w_r == 4'd0) || (w_r > 4'd8);
    sts.slot_bad   = {1'b0, slot_r} >= 9'(kmst_pkg::SLOT_LIMIT);
    sts.count_zero = (cnt_r == '0);
    sts.full       = (cnt_r == kmst_pkg::CNT_W'(kmst_pkg::MAX_ENTRIES));
    sts.key_match  = (key_q == key_r);
    sts.idx_last   = ((kmst_pkg::CNT_W'(idx_r) + 1'b1) == cnt_r);
    sts.changed    = (merged != cur);
    sts.wide       = (wid_q > 4'd1);
    sts.acc_ge8    = (sum_bits >= 5'd8);
    sts.acc_left   = (sum_bits != 5'd8) && (sum_bits != 5'd0);
  end

endmodule
`default_nettype wire

/* rtl/core/kmst_ctrl.sv */
// keyed monotone state table controller: sequences key search,
// append, update and snapshot runs; uses kmst_pkg
`default_nettype none
module kmst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire kmst_pkg::sts_t sts,
  output kmst_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_APP  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_EMV  = 4'd6;
  localparam logic [3:0] S_SNS  = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SACC = 4'd9;
  localparam logic [3:0] S_SFL  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        unique case (sts.action)
          kmst_pkg::ACT_CLEAR: begin
            cmd.cnt_clr  = 1'b1;
            cmd.sess_clr = 1'b1;
          end
          kmst_pkg::ACT_APPEND: begin
            if (sts.bad_fields) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = kmst_pkg::ST_BAD_ENTRY;
              cmd.emit_last   = 1'b1;
            end else if (sts.count_zero) begin
              state_nxt = S_APP;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_RD;
            end
          end
          kmst_pkg::ACT_OPEN: begin
            cmd.live_clr = 1'b1;
            cmd.sess_set = 1'b1;
          end
          kmst_pkg::ACT_CLOSE: begin
            cmd.sess_clr = 1'b1;
          end
          kmst_pkg::ACT_UPDATE: begin
            if (sts.session) begin
              if (sts.count_zero) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = kmst_pkg::ST_UNKNOWN;
                cmd.emit_last   = 1'b1;
              end else begin
                cmd.idx_clr = 1'b1;
                state_nxt   = S_RD;
              end
            end
          end
          kmst_pkg::ACT_SNAP: begin
            if (sts.slot_bad) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = kmst_pkg::ST_BAD_SLOT;
              cmd.emit_last   = 1'b1;
            end else if (sts.session) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = kmst_pkg::SEL_HDR;
              state_nxt    = S_SNS;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.key_match) begin
          if (sts.action == kmst_pkg::ACT_APPEND) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = kmst_pkg::ST_BAD_ENTRY;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_UPD;
          end
        end else if (sts.idx_last) begin
          if (sts.action == kmst_pkg::ACT_APPEND) begin
            state_nxt = S_APP;
          end else begin
            cmd.emit        = 1'b1;
            cmd.emit_status = kmst_pkg::ST_UNKNOWN;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_APP: begin
        state_nxt = S_IDLE;
        if (sts.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = kmst_pkg::ST_FULL;
          cmd.emit_last   = 1'b1;
        end else begin
          cmd.wr_entry = 1'b1;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
        if (sts.changed) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = kmst_pkg::SEL_IDX;
          cmd.emit_last = !sts.wide;
          if (sts.wide) begin
            state_nxt = S_EMV;
          end else begin
            cmd.wr_val = 1'b1;
          end
        end
      end
      S_EMV: begin
        // value written here so the merge still sees the old value
        cmd.emit      = 1'b1;
        cmd.emit_sel  = kmst_pkg::SEL_VAL;
        cmd.emit_last = 1'b1;
        cmd.wr_val    = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SNS: begin
        cmd.emit      = 1'b1;
        cmd.emit_sel  = kmst_pkg::SEL_SLOT;
        cmd.emit_last = sts.count_zero;
        cmd.idx_clr   = 1'b1;
        cmd.acc_clr   = 1'b1;
        state_nxt     = sts.count_zero ? S_IDLE : S_SRD;
      end
      S_SRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SACC;
      end
      S_SACC: begin
        cmd.acc_add   = 1'b1;
        cmd.emit      = sts.acc_ge8;
        cmd.emit_sel  = kmst_pkg::SEL_ACC;
        cmd.emit_last = sts.idx_last && !sts.acc_left;
        if (sts.idx_last) begin
          state_nxt = sts.acc_left ? S_SFL : S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SFL: begin
        cmd.emit      = 1'b1;
        cmd.emit_sel  = kmst_pkg::SEL_FLUSH;
        cmd.emit_last = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/keyed_monotone_state_table.sv */
// keyed monotone state table top level: joins controller and datapath
// depends on kmst_pkg, kmst_ctrl, kmst_dp
//
// Usage: an item is taken when start is high and busy is low; busy stays
// high until the item's work is done. Actions: clear, append, open
// session, close session, update, snapshot.
// Results appear one per cycle-wide strobe on out_valid with out_status,
// out_data_byte and out_last; the receiver cannot stall them.
// Sequence: clear, open, close and bad appends finish in S_DEC. Append and
// update search the key store one entry at a time (one read port with
// registered data: S_RD reads, S_CMP compares), then S_APP writes or
// S_UPD and S_EMV give the result bytes. A snapshot gives the header and
// slot, then one packed byte at most per entry read, plus a flush of any bits left.
// Results are registered: each shows in the cycle after the state that makes it.
// Reset empties the table and closes the session; stored entries are
// left as they are and are never read before they are written again.
`default_nettype none
module keyed_monotone_state_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_binding_id,
  input  wire logic [3:0]  in_entry_width,
  input  wire logic        in_merge_max,
  input  wire logic [7:0]  in_incoming_value,
  input  wire logic [7:0]  in_slot,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_data_byte,
  output logic             out_last
);

  kmst_pkg::cmd_t cmd;
  kmst_pkg::sts_t sts;

  kmst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  kmst_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_action),
    .in_binding_id     (in_binding_id),
    .in_entry_width    (in_entry_width),
    .in_merge_max      (in_merge_max),
    .in_incoming_value (in_incoming_value),
    .in_slot           (in_slot),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

/* rtl/core/kmst_checker.sv */
// keyed monotone state table port checker and its bind
// depends on kmst_pkg and the top level's ports
`default_nettype none
module kmst_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_data_byte,
  input wire logic       out_last
);

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item taken but block not busy");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != kmst_pkg::ST_DATA) |-> out_last && (out_data_byte == 8'h00))
    else $error("error result not a run of one");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("run unfinished while idle");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind keyed_monotone_state_table kmst_checker u_kmst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_data_byte (out_data_byte),
  .out_last      (out_last)
);
`default_nettype wire

/* verif/tb_top.sv */
// testbench for keyed_monotone_state_table: directed table, a full table, then random sequences
// checks every result against an in-bench prediction of the table
// depends on kmst_pkg and the keyed_monotone_state_table rtl
`timescale 1ns / 1ps
module tb_top;
  import kmst_pkg::*;

  typedef struct {
    logic [2:0] status;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] id;
    logic [3:0]  width;
    logic        mmax;
    logic [7:0]  value;
    logic [7:0]  slot;
    bit          typed;
    logic [2:0]  t_status;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_action;
  logic [31:0] in_binding_id;
  logic [3:0]  in_entry_width;
  logic        in_merge_max;
  logic [7:0]  in_incoming_value;
  logic [7:0]  in_slot;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte;
  logic        out_last;

  keyed_monotone_state_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_binding_id(in_binding_id),
    .in_entry_width(in_entry_width), .in_merge_max(in_merge_max),
    .in_incoming_value(in_incoming_value), .in_slot(in_slot),
    .out_valid(out_valid), .out_status(out_status),
    .out_data_byte(out_data_byte), .out_last(out_last)
  );

  // table model
  logic [31:0] key_mem [MAX_ENTRIES];
  logic [3:0]  width_mem [MAX_ENTRIES];
  logic        mode_mem [MAX_ENTRIES];
  logic [7:0]  value_mem [MAX_ENTRIES];
  int          entries;
  bit          in_session;

  res_t pending_q[$];
  int   errors;
  int   items_sent;
  int   results_seen;
  int   snaps_seen;
  bit   no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int find_entry(input logic [31:0] id);
    for (int i = 0; i < entries; i++) begin
      if (key_mem[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void push_res(input logic [2:0] st, input logic [7:0] b, input logic l);
    res_t r;
    r.status = st;
    r.data = b;
    r.last = l;
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void predict_table(input row_t it);
    int idx;
    int at;
    int nbytes;
    logic [7:0] mask;
    logic [7:0] inc;
    logic [7:0] nxt;
    logic [7:0] packed_b [MAX_ENTRIES + 1];
    case (it.act)
      ACT_CLEAR: begin
        entries = 0;
        in_session = 1'b0;
      end
      ACT_APPEND: begin
        if (it.id == 0 || it.width == 0 || it.width > 8 || find_entry(it.id) >= 0)
          push_res(ST_BAD_ENTRY, 8'h00, 1'b1);
        else if (entries >= MAX_ENTRIES)
          push_res(ST_FULL, 8'h00, 1'b1);
        else begin
          key_mem[entries] = it.id;
          width_mem[entries] = it.width;
          mode_mem[entries] = it.mmax;
          value_mem[entries] = 8'h00;
          entries++;
        end
      end
      ACT_OPEN: begin
        for (int i = 0; i < MAX_ENTRIES; i++) value_mem[i] = 8'h00;
        in_session = 1'b1;
      end
      ACT_CLOSE: in_session = 1'b0;
      ACT_UPDATE: begin
        if (in_session) begin
          idx = find_entry(it.id);
          if (idx < 0) push_res(ST_UNKNOWN, 8'h00, 1'b1);
          else begin
            mask = 8'((9'h1 << width_mem[idx]) - 9'h1);
            inc = it.value & mask;
            if (mode_mem[idx]) nxt = (inc > value_mem[idx]) ? inc : value_mem[idx];
            else nxt = value_mem[idx] | inc;
            if (nxt != value_mem[idx]) begin
              value_mem[idx] = nxt;
              if (width_mem[idx] > 1) begin
                push_res(ST_DATA, 8'(idx), 1'b0);
                push_res(ST_DATA, nxt, 1'b1);
              end else begin
                push_res(ST_DATA, 8'(idx), 1'b1);
              end
            end
          end
        end
      end
      ACT_SNAP: begin
        if (it.slot >= SLOT_LIMIT) push_res(ST_BAD_SLOT, 8'h00, 1'b1);
        else if (in_session) begin
          for (int i = 0; i <= MAX_ENTRIES; i++) packed_b[i] = 8'h00;
          at = 0;
          for (int i = 0; i < entries; i++) begin
            for (int j = 0; j < width_mem[i]; j++) begin
              packed_b[at / 8][at % 8] = value_mem[i][j];
              at++;
            end
          end
          nbytes = (at + 7) / 8;
          push_res(ST_DATA, SNAP_HEADER, 1'b0);
          push_res(ST_DATA, it.slot, nbytes == 0);
          for (int i = 0; i < nbytes; i++) push_res(ST_DATA, packed_b[i], i + 1 == nbytes);
          snaps_seen++;
        end
      end
      default: ;
    endcase
  endfunction

  // drive at the falling edge, once busy is low
  task automatic send_item(input row_t it);
    int queued_n;
    while (busy) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_action = it.act;
    in_binding_id = it.id;
    in_entry_width = it.width;
    in_merge_max = it.mmax;
    in_incoming_value = it.value;
    in_slot = it.slot;
    queued_n = pending_q.size();
    predict_table(it);
    if (it.typed) begin
      while (pending_q.size() > queued_n) void'(pending_q.pop_back());
      push_res(it.t_status, 8'h00, 1'b1);
    end
    if (it.act <= ACT_SNAP) items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (90) @(negedge clk);
  endtask

  function automatic row_t mk(input logic [2:0] a, input logic [31:0] id, input logic [3:0] w,
                              input logic mm, input logic [7:0] v, input logic [7:0] s);
    row_t r;
    r.act = a;
    r.id = id;
    r.width = w;
    r.mmax = mm;
    r.value = v;
    r.slot = s;
    r.typed = 1'b0;
    r.t_status = ST_DATA;
    return r;
  endfunction

  function automatic logic [31:0] pick_id();
    if (entries > 0 && $urandom_range(0, 9) < 8) return key_mem[$urandom_range(0, entries - 1)];
    return $urandom();
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) report("result with nothing expected");
      else begin
        e = pending_q.pop_front();
        if (out_status !== e.status)
          report($sformatf("status %0d, expected %0d", out_status, e.status));
        if (out_data_byte !== e.data)
          report($sformatf("data %02h, expected %02h", out_data_byte, e.data));
        if (out_last !== e.last)
          report($sformatf("last %0b, expected %0b", out_last, e.last));
      end
    end
  end

  row_t dir_rows[$];

  function automatic void add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    row_t r;
    int n;
    int limit;
    start = 1'b0;
    in_action = ACT_CLEAR;
    in_binding_id = '0;
    in_entry_width = '0;
    in_merge_max = 1'b0;
    in_incoming_value = '0;
    in_slot = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    snaps_seen = 0;
    no_gaps = 1'b0;
    entries = 0;
    in_session = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    add_row(mk(ACT_UPDATE, 32'h1, 4'd1, 1'b0, 8'hff, 8'd0));
    r = mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd24); r.typed = 1; r.t_status = ST_BAD_SLOT;
    add_row(r);
    add_row(mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    r = mk(ACT_APPEND, 32'h0, 4'd4, 1'b0, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_BAD_ENTRY;
    add_row(r);
    r = mk(ACT_APPEND, 32'h9, 4'd0, 1'b0, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_BAD_ENTRY;
    add_row(r);
    r = mk(ACT_APPEND, 32'h9, 4'd9, 1'b1, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_BAD_ENTRY;
    add_row(r);
    r = mk(ACT_APPEND, 32'h9, 4'd15, 1'b1, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_BAD_ENTRY;
    add_row(r);
    add_row(mk(ACT_OPEN, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    add_row(mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd7));
    add_row(mk(ACT_APPEND, 32'hffffffff, 4'd8, 1'b1, 8'h00, 8'd0));
    add_row(mk(ACT_APPEND, 32'h1, 4'd1, 1'b0, 8'h00, 8'd0));
    r = mk(ACT_APPEND, 32'hffffffff, 4'd3, 1'b0, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_BAD_ENTRY;
    add_row(r);
    add_row(mk(ACT_APPEND, 32'h5, 4'd3, 1'b0, 8'h00, 8'd0));
    r = mk(ACT_UPDATE, 32'h7, 4'd0, 1'b0, 8'h01, 8'd0); r.typed = 1; r.t_status = ST_UNKNOWN;
    add_row(r);
    add_row(mk(ACT_UPDATE, 32'hffffffff, 4'd0, 1'b0, 8'hff, 8'd0));
    add_row(mk(ACT_UPDATE, 32'h1, 4'd0, 1'b0, 8'hff, 8'd0));
    add_row(mk(ACT_UPDATE, 32'h1, 4'd0, 1'b0, 8'hff, 8'd0));
    add_row(mk(ACT_UPDATE, 32'h5, 4'd0, 1'b0, 8'ha5, 8'd0));
    add_row(mk(ACT_UPDATE, 32'hffffffff, 4'd0, 1'b0, 8'h10, 8'd0));
    add_row(mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd23));
    r = mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd255); r.typed = 1; r.t_status = ST_BAD_SLOT;
    add_row(r);
    add_row(mk(ACT_CLOSE, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    add_row(mk(ACT_UPDATE, 32'h5, 4'd0, 1'b0, 8'hff, 8'd0));
    add_row(mk(3'd6, 32'h5, 4'd2, 1'b1, 8'hff, 8'd1));
    add_row(mk(3'd7, 32'h5, 4'd2, 1'b1, 8'hff, 8'd1));
    @(negedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // fill the table, then one more append
    send_item(mk(ACT_CLEAR, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    for (int i = 0; i < MAX_ENTRIES; i++)
      send_item(mk(ACT_APPEND, $urandom() | 32'h1, 4'($urandom_range(1, 8)), 1'($urandom()),
                   8'h00, 8'd0));
    r = mk(ACT_APPEND, 32'h12345678, 4'd4, 1'b0, 8'h00, 8'd0); r.typed = 1; r.t_status = ST_FULL;
    if (find_entry(32'h12345678) < 0 && entries == MAX_ENTRIES) send_item(r);
    send_item(mk(ACT_OPEN, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    send_item(mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
    drain();

    // random sequences: build a table, open, then mostly updates and snapshots mixed with other actions
    limit = 270;
    while (items_sent < limit) begin
      no_gaps = (limit - items_sent) < 40;
      send_item(mk(ACT_CLEAR, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        r = mk(ACT_APPEND, $urandom(), 4'($urandom_range(1, 8)), 1'($urandom()), 8'h00, 8'd0);
        if ($urandom_range(0, 9) == 0) r.width = 4'($urandom());
        if ($urandom_range(0, 11) == 0) r.id = pick_id();
        if ($urandom_range(0, 40) == 0) r.id = 32'h0;
        send_item(r);
        maybe_gap();
      end
      send_item(mk(ACT_OPEN, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0));
      n = $urandom_range(4, 14);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: r = mk(ACT_SNAP, 32'h0, 4'd0, 1'b0, 8'h00,
                          ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 23)));
          3: r = mk(3'($urandom_range(0, 7)), $urandom(), 4'($urandom()), 1'($urandom()),
                    8'($urandom()), 8'($urandom()));
          4: r = mk(ACT_CLOSE, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0);
          5: r = mk(ACT_OPEN, 32'h0, 4'd0, 1'b0, 8'h00, 8'd0);
          6: r = mk(ACT_APPEND, $urandom(), 4'($urandom_range(1, 8)), 1'($urandom()),
                    8'h00, 8'd0);
          default: r = mk(ACT_UPDATE, pick_id(), 4'd0, 1'b0, 8'($urandom()), 8'd0);
        endcase
        if (r.act == ACT_CLEAR && $urandom_range(0, 1) == 0) r.act = ACT_UPDATE;
        send_item(r);
        maybe_gap();
      end
      if ($urandom_range(0, 5) == 0 && !no_gaps) drain();
    end
    drain();

    $display("%0d items sent, %0d results checked, %0d snapshots", items_sent,
             results_seen, snaps_seen);
    $display("covered bad appends, full table, unknown ids, bad slots and idle gaps");
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
